FILE: hdl/fmd_pkg.sv
// ----------------------------------------------------------------------------
// fmd_pkg
// Types and constants for the FM quadrature discriminator.
// ----------------------------------------------------------------------------
`default_nettype none

package fmd_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int RESULT_FRAC_BITS = 12;
    localparam int OUT_W            = 16;

    // products, numerator, squared magnitude
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int NUM_W  = 2 * SAMPLE_BITS + 1;
    localparam int MAG_W  = 2 * SAMPLE_BITS;
    localparam int ANUM_W = 2 * SAMPLE_BITS;

    // divider: quotient bits kept, one more than the output
    localparam int QBITS = OUT_W + 1;
    localparam int CMP_W = MAG_W + QBITS;
    localparam int CNT_W = $clog2(QBITS + 1);

    localparam int MUL_STEPS = 4;

    localparam logic [QBITS-1:0] QUOT_MAX_POS = QBITS'(2 ** (OUT_W - 1) - 1);
    localparam logic [QBITS-1:0] QUOT_MAX_NEG = QBITS'(2 ** (OUT_W - 1));

    localparam logic [OUT_W-1:0] OUT_POS_LIMIT = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_NEG_LIMIT = {1'b1, {(OUT_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] i_sample;
        logic signed [SAMPLE_BITS-1:0] q_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] demod_value;
        logic                    saturated;
    } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/fm_discriminator_demod.sv
// ----------------------------------------------------------------------------
// fm_discriminator_demod
// FM quadrature discriminator: (Iprev*Q - Qprev*I) / (I*I + Q*Q), Q4.12 out.
// ----------------------------------------------------------------------------
// Items are taken one at a time: in_ready is high only in idle, so a new item
// waits until the last one has been presented. Each item makes four passes
// through the shared multiplier and the 18 steps of the restoring divider; it
// skips the divider when I = Q = 0 and stops after its first step on overflow.
// Reset: asynchronous, clears the previous sample to (0, 0) and the FSM to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_discriminator_demod #(
    parameter int RESULT_FRAC_BITS = fmd_pkg::RESULT_FRAC_BITS
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  fmd_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  wire                 out_ready,
    output fmd_pkg::out_item_t  out_item
);

    localparam int SB     = fmd_pkg::SAMPLE_BITS;
    localparam int PROD_W = fmd_pkg::PROD_W;
    localparam int NUM_W  = fmd_pkg::NUM_W;
    localparam int MAG_W  = fmd_pkg::MAG_W;
    localparam int ANUM_W = fmd_pkg::ANUM_W;
    localparam int QBITS  = fmd_pkg::QBITS;
    localparam int CMP_W  = fmd_pkg::CMP_W;
    localparam int CNT_W  = fmd_pkg::CNT_W;
    localparam int OUT_W  = fmd_pkg::OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [SB-1:0]     prev_i_reg, prev_i_next;
    logic signed [SB-1:0]     prev_q_reg, prev_q_next;
    logic                     out_valid_reg, out_valid_next;
    fmd_pkg::out_item_t       out_item_reg, out_item_next;

    logic signed [SB-1:0]     cur_i_reg, cur_i_next;
    logic signed [SB-1:0]     cur_q_reg, cur_q_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [CMP_W-1:0]         rem_reg, rem_next;
    logic [CMP_W-1:0]         dsh_reg, dsh_next;
    logic [QBITS-1:0]         quot_reg, quot_next;
    logic                     neg_reg, neg_next;
    logic                     ovf_reg, ovf_next;
    logic                     zero_reg, zero_next;

    logic signed [SB-1:0]     mul_a;
    logic signed [SB-1:0]     mul_b;
    logic signed [NUM_W-1:0]  num_abs;
    logic                     ge;
    logic [QBITS-1:0]         quot_neg;
    fmd_pkg::out_item_t       result;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (cnt_reg)
            CNT_W'(0):
            begin
                mul_a = prev_i_reg;
                mul_b = cur_q_reg;
            end
            CNT_W'(1):
            begin
                mul_a = prev_q_reg;
                mul_b = cur_i_reg;
            end
            CNT_W'(2):
            begin
                mul_a = cur_i_reg;
                mul_b = cur_i_reg;
            end
            default:
            begin
                mul_a = cur_q_reg;
                mul_b = cur_q_reg;
            end
        endcase
    end

    assign num_abs  = num_reg[NUM_W-1] ? -num_reg : num_reg;
    assign ge       = (rem_reg >= dsh_reg);
    assign quot_neg = ~quot_reg + 1'b1;

    always_comb
    begin
        result.demod_value = '0;
        result.saturated   = 1'b0;
        if (zero_reg)
        begin
            result.demod_value = '0;
        end
        else if (neg_reg)
        begin
            if (ovf_reg || (quot_reg > fmd_pkg::QUOT_MAX_NEG))
            begin
                result.demod_value = fmd_pkg::OUT_NEG_LIMIT;
                result.saturated   = 1'b1;
            end
            else
            begin
                result.demod_value = quot_neg[OUT_W-1:0];
            end
        end
        else
        begin
            if (ovf_reg || (quot_reg > fmd_pkg::QUOT_MAX_POS))
            begin
                result.demod_value = fmd_pkg::OUT_POS_LIMIT;
                result.saturated   = 1'b1;
            end
            else
            begin
                result.demod_value = quot_reg[OUT_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        prev_i_next    = prev_i_reg;
        prev_q_next    = prev_q_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        cur_i_next     = cur_i_reg;
        cur_q_next     = cur_q_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quot_next      = quot_reg;
        neg_next       = neg_reg;
        ovf_next       = ovf_reg;
        zero_next      = zero_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_i_next = in_item.i_sample;
                    cur_q_next = in_item.q_sample;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = mul_a * mul_b;
                // accumulate the product of the previous step
                case (cnt_reg)
                    CNT_W'(1): num_next = NUM_W'(prod_reg);
                    CNT_W'(2): num_next = num_reg - NUM_W'(prod_reg);
                    CNT_W'(3): mag_next = prod_reg[MAG_W-1:0];
                    CNT_W'(4): mag_next = mag_reg + prod_reg[MAG_W-1:0];
                    default:   num_next = num_reg;
                endcase
                if (cnt_reg == CNT_W'(fmd_pkg::MUL_STEPS))
                begin
                    prev_i_next = cur_i_reg;
                    prev_q_next = cur_q_reg;
                    state_next  = ST_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PREP:
            begin
                neg_next  = num_reg[NUM_W-1];
                rem_next  = CMP_W'(num_abs[ANUM_W-1:0]) << RESULT_FRAC_BITS;
                dsh_next  = CMP_W'(mag_reg) << QBITS;
                quot_next = '0;
                ovf_next  = 1'b0;
                zero_next = (mag_reg == '0);
                cnt_next  = '0;
                state_next = (mag_reg == '0) ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    // first step only tests for a quotient beyond QBITS
                    if (ge)
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    quot_next = {quot_reg[QBITS-2:0], ge};
                    if (cnt_reg == CNT_W'(QBITS))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_item_next  = result;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prev_i_reg    <= prev_i_next;
            prev_q_reg    <= prev_q_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_i_reg <= cur_i_next;
        cur_q_reg <= cur_q_next;
        prod_reg  <= prod_next;
        num_reg   <= num_next;
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quot_reg  <= quot_next;
        neg_reg   <= neg_next;
        ovf_reg   <= ovf_next;
        zero_reg  <= zero_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.saturated |->
            (out_item.demod_value == fmd_pkg::OUT_POS_LIMIT) ||
            (out_item.demod_value == fmd_pkg::OUT_NEG_LIMIT))
        else $error("saturated flag without a limit value");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> (mag_reg != '0) && (dsh_reg != '0))
        else $error("divider running with zero divisor");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= CNT_W'(QBITS))
        else $error("divider step count out of range");

    a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && (!out_valid || out_ready) |=> out_valid && in_ready)
        else $error("finished item not presented");

endmodule

`default_nettype wire
